// ===== src/tnas_pkg.sv =====
// Shared types and constants for the top-N argmax selector.
// No dependencies; used by every module under src/.
package tnas_pkg;

    localparam int MAX_TOP     = 8;
    localparam int MAX_CLASSES = 4096;
    localparam int SCORE_W     = 32;
    localparam int IDX_W       = 12;
    localparam int TOPC_W      = 4;
    localparam int ARR_W       = $clog2(MAX_CLASSES + 1);
    localparam int KEPT_W      = $clog2(MAX_TOP + 1);
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [TOPC_W-1:0] TOP_COUNT_RESET = TOPC_W'(5);

    // Input request
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      final_item;
    } in_item_t;

    // Result request
    typedef struct packed {
        logic [IDX_W-1:0]          class_index;
        logic signed [SCORE_W-1:0] class_score;
        logic                      last_of_run;
    } out_item_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [IDX_W-1:0]          pos;
        logic                      rank;
        logic                      final_item;
    } q_item_t;

    // One kept entry
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [IDX_W-1:0]          pos;
    } entry_t;

    // Sorter to drain control
    typedef struct packed {
        logic              load;
        logic [KEPT_W-1:0] count;
    } drain_ctl_t;

endpackage

// ===== src/tnas_front.sv =====
// Front end: accepts scores, numbers them by arrival and queues them.
// Depends on tnas_pkg.
module tnas_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tnas_pkg::in_item_t  s_data,
    output logic                q_valid,
    input  logic                q_ready,
    output tnas_pkg::q_item_t   q_data
);

    logic [tnas_pkg::ARR_W-1:0]      arr_cnt_reg, arr_cnt_next;
    logic [tnas_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tnas_pkg::FIFO_CNT_W-1:0] fill_reg, fill_next;
    tnas_pkg::q_item_t               fifo_mem [tnas_pkg::FIFO_DEPTH];
    tnas_pkg::q_item_t               cls;
    logic                            push, pop;

    assign s_ready = (fill_reg != tnas_pkg::FIFO_CNT_W'(tnas_pkg::FIFO_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_data  = fifo_mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Classify: position and whether the item is still ranked
    always_comb begin
        cls.score      = s_data.score;
        cls.pos        = arr_cnt_reg[tnas_pkg::IDX_W-1:0];
        cls.rank       = (arr_cnt_reg < tnas_pkg::ARR_W'(tnas_pkg::MAX_CLASSES));
        cls.final_item = s_data.final_item;
    end

    // Arrival counter, saturating, cleared at vector end
    always_comb begin
        arr_cnt_next = arr_cnt_reg;
        if (push) begin
            if (s_data.final_item) begin
                arr_cnt_next = '0;
            end else if (cls.rank) begin
                arr_cnt_next = arr_cnt_reg + 1'b1;
            end
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arr_cnt_reg <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
        end else begin
            arr_cnt_reg <= arr_cnt_next;
            fill_reg    <= fill_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == tnas_pkg::FIFO_PTR_W'(tnas_pkg::FIFO_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == tnas_pkg::FIFO_PTR_W'(tnas_pkg::FIFO_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= cls;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= tnas_pkg::FIFO_CNT_W'(tnas_pkg::FIFO_DEPTH))
        else $error("queue fill above depth");

    a_arr_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && s_data.final_item) |=> (arr_cnt_reg == '0))
        else $error("arrival counter not cleared at vector end");

endmodule

// ===== src/tnas_sorter.sv =====
// Back end sorter: compare-and-shift insertion into the kept list.
// Depends on tnas_pkg.
module tnas_sorter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [tnas_pkg::TOPC_W-1:0]   top_count,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  tnas_pkg::q_item_t             q_data,
    input  logic                          can_load,
    output tnas_pkg::drain_ctl_t          dctl,
    output tnas_pkg::entry_t              load_entries [tnas_pkg::MAX_TOP]
);

    tnas_pkg::entry_t            kept_reg [tnas_pkg::MAX_TOP];
    tnas_pkg::entry_t            ins      [tnas_pkg::MAX_TOP];
    tnas_pkg::entry_t            new_ent;
    logic [tnas_pkg::MAX_TOP-1:0] ge;
    logic [tnas_pkg::KEPT_W-1:0] kept_cnt_reg, kept_cnt_next, cnt_ins, clamp_n;
    logic                        pop, take;

    assign q_ready = !q_data.final_item || can_load;
    assign pop     = q_valid && q_ready;
    assign take    = pop && q_data.rank && !ge[tnas_pkg::MAX_TOP-1];

    // Per-cell compare and shift select
    always_comb begin
        new_ent.score = q_data.score;
        new_ent.pos   = q_data.pos;
        for (int i = 0; i < tnas_pkg::MAX_TOP; i++) begin
            ge[i] = (i < int'(kept_cnt_reg)) && (kept_reg[i].score >= q_data.score);
        end
        for (int i = 0; i < tnas_pkg::MAX_TOP; i++) begin
            if (ge[i]) begin
                ins[i] = kept_reg[i];
            end else if (i == 0) begin
                ins[i] = new_ent;
            end else if (ge[(i == 0) ? 0 : i - 1]) begin
                ins[i] = new_ent;
            end else begin
                ins[i] = kept_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // Entry count after this insertion
    always_comb begin
        cnt_ins = kept_cnt_reg;
        if (take && (int'(kept_cnt_reg) < tnas_pkg::MAX_TOP)) begin
            cnt_ins = kept_cnt_reg + 1'b1;
        end
        kept_cnt_next = kept_cnt_reg;
        if (pop) begin
            kept_cnt_next = q_data.final_item ? '0 : cnt_ins;
        end
    end

    // Report count: top_count clamped to 1..MAX_TOP, then to entries seen
    always_comb begin
        if (top_count == '0) begin
            clamp_n = tnas_pkg::KEPT_W'(1);
        end else if (int'(top_count) > tnas_pkg::MAX_TOP) begin
            clamp_n = tnas_pkg::KEPT_W'(tnas_pkg::MAX_TOP);
        end else begin
            clamp_n = tnas_pkg::KEPT_W'(top_count);
        end
        dctl.load  = pop && q_data.final_item;
        dctl.count = (clamp_n < cnt_ins) ? clamp_n : cnt_ins;
        for (int i = 0; i < tnas_pkg::MAX_TOP; i++) begin
            load_entries[i] = take ? ins[i] : kept_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_cnt_reg <= '0;
        end else begin
            kept_cnt_reg <= kept_cnt_next;
        end
    end

    // Kept list, no reset on payload
    always_ff @(posedge aclk) begin
        if (take) begin
            kept_reg <= ins;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(kept_cnt_reg) <= tnas_pkg::MAX_TOP)
        else $error("kept count above list depth");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (kept_cnt_reg >= tnas_pkg::KEPT_W'(2)) |-> (kept_reg[0].score >= kept_reg[1].score))
        else $error("kept list out of order");

    a_final_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_data.final_item && !can_load) |=> q_valid)
        else $error("final request dropped while drain busy");

endmodule

// ===== src/tnas_drain.sv =====
// Back end drain: holds a snapshot of the ranked list and shifts it out.
// Depends on tnas_pkg.
module tnas_drain (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tnas_pkg::drain_ctl_t     dctl,
    input  tnas_pkg::entry_t         load_entries [tnas_pkg::MAX_TOP],
    output logic                     can_load,
    output logic                     m_valid,
    input  logic                     m_ready,
    output tnas_pkg::out_item_t      m_data
);

    tnas_pkg::entry_t            buf_reg [tnas_pkg::MAX_TOP];
    logic [tnas_pkg::KEPT_W-1:0] left_reg, left_next;
    logic                        m_take;

    assign m_valid  = (left_reg != '0);
    assign m_take   = m_valid && m_ready;
    assign can_load = (left_reg == '0) ||
                      ((left_reg == tnas_pkg::KEPT_W'(1)) && m_ready);

    // Head of the buffer is the current result
    always_comb begin
        m_data.class_index = buf_reg[0].pos;
        m_data.class_score = buf_reg[0].score;
        m_data.last_of_run = (left_reg == tnas_pkg::KEPT_W'(1));
    end

    always_comb begin
        left_next = left_reg;
        if (dctl.load) begin
            left_next = dctl.count;
        end else if (m_take) begin
            left_next = left_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else begin
            left_reg <= left_next;
        end
    end

    // Snapshot load or shift toward the head
    always_ff @(posedge aclk) begin
        if (dctl.load) begin
            buf_reg <= load_entries;
        end else if (m_take) begin
            for (int i = 0; i < tnas_pkg::MAX_TOP - 1; i++) begin
                buf_reg[i] <= buf_reg[i + 1];
            end
        end
    end

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        dctl.load |-> can_load)
        else $error("drain loaded while results pending");

    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_take && !dctl.load) |=> (left_reg == $past(left_reg) - 1'b1))
        else $error("drain count did not step");

endmodule

// ===== src/top_n_argmax_select_unit.sv =====
// Top-N argmax selector: an accepted final score passes the queue register into the
// drain snapshot, then one result per cycle while m_ready is high: top_count results
// per vector, clamped to 1..MAX_TOP and to the ranked scores seen. Throughput is one
// score per cycle while the queue has room; a final score waits in the queue only
// while the previous vector's results are still draining. aresetn (synchronous,
// active low) clears counters and queues and sets top_count to 5, not the kept list.
module top_n_argmax_select_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tnas_pkg::TOPC_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tnas_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tnas_pkg::out_item_t           m_data
);

    logic [tnas_pkg::TOPC_W-1:0] top_count_reg;
    logic                        q_valid, q_ready, can_load;
    tnas_pkg::q_item_t           q_data;
    tnas_pkg::drain_ctl_t        dctl;
    tnas_pkg::entry_t            load_entries [tnas_pkg::MAX_TOP];

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_count_reg <= tnas_pkg::TOP_COUNT_RESET;
        end else if (cfg_we) begin
            top_count_reg <= cfg_wdata;
        end
    end

    tnas_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    tnas_sorter u_sorter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .top_count    (top_count_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_data       (q_data),
        .can_load     (can_load),
        .dctl         (dctl),
        .load_entries (load_entries)
    );

    tnas_drain u_drain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .dctl         (dctl),
        .load_entries (load_entries),
        .can_load     (can_load),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule
